### design/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// Types and constants shared by the chunk reorder and reassembly unit.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int OffW       = 48;
    localparam int LenW       = 21;
    localparam int SlotW      = 5;
    localparam int LimW       = 6;
    localparam int MaxResults = 32;
    localparam int CntW       = $clog2(MaxResults + 1);

    // input word layout
    localparam int InDataW  = 72;
    // output word layout
    localparam int OutDataW = 80;

    localparam logic ActStore = 1'b0;
    localparam logic ActDrain = 1'b1;

    localparam logic CfgSlotLimit   = 1'b0;
    localparam logic CfgStartOffset = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMIT   = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STORE,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic wr;   // write descriptor and mark slot used
        logic clr;  // free slot
    } tbl_cmd_t;

endpackage

### design/cra_slot_table.sv
// ----------------------------------------------------------------------------
// cra_slot_table
// Slot used flags plus descriptor memory with one write and one registered
// read port.
// ----------------------------------------------------------------------------
module cra_slot_table #(
    parameter int SLOTS = 32,
    parameter int IW    = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cra_pkg::tbl_cmd_t        cmd,
    input  logic [IW-1:0]            idx,
    input  logic [cra_pkg::OffW-1:0] wr_offset,
    input  logic [cra_pkg::LenW-1:0] wr_length,
    input  logic [IW-1:0]            rd_idx,
    output logic [cra_pkg::OffW-1:0] rd_offset,
    output logic [cra_pkg::LenW-1:0] rd_length,
    output logic [SLOTS-1:0]         used
);

    logic [cra_pkg::OffW-1:0] mem_off [SLOTS];
    logic [cra_pkg::LenW-1:0] mem_len [SLOTS];
    logic [SLOTS-1:0]         used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.wr)
        begin
            used_reg[idx] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            used_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_off[idx] <= wr_offset;
            mem_len[idx] <= wr_length;
        end
        rd_offset <= mem_off[rd_idx];
        rd_length <= mem_len[rd_idx];
    end

    assign used = used_reg;

endmodule

### design/chunk_reorder_reassembly_unit.sv
// ----------------------------------------------------------------------------
// chunk_reorder_reassembly_unit
// Slot table that puts out-of-order chunk descriptors back in stream order.
// ----------------------------------------------------------------------------
// Words enter on the s_ side: tuser selects store (0) or drain (1), tdata
// carries the chunk offset and length. A store takes the lowest free slot
// below slot_limit and returns one word: stored with its slot, or full.
// A drain sweeps the slots in index order, repeating whole passes, and
// returns one word per chunk whose offset matches the expected offset;
// tlast marks the final word of the drain. A drain that finds nothing
// returns one "nothing ready" word.
// One slot is visited per cycle, except while the sweep pauses, through
// the single read port of the descriptor memory; a drain returns at most
// 32 chunks.
// s_tready is high only between words. A stalled m_ side holds the
// result register; the sweep then pauses at the next hit.
// Reset frees every slot and clears the expected offset to zero;
// writing start_offset loads it. Configure only while idle.
// ----------------------------------------------------------------------------
module chunk_reorder_reassembly_unit #(
    parameter int SLOTS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [cra_pkg::OffW-1:0]        cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [47:0] chunk_offset, [68:48] chunk_length, [71:69] zero
    input  logic [cra_pkg::InDataW-1:0]     s_tdata,
    // [0] action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] slot_index, [52:5] out_offset, [73:53] out_length, [79:74] zero
    output logic [cra_pkg::OutDataW-1:0]    m_tdata,
    // [1:0] status
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OffW = cra_pkg::OffW;
    localparam int LenW = cra_pkg::LenW;
    localparam int SlotW = cra_pkg::SlotW;
    localparam int CntW = cra_pkg::CntW;

    cra_pkg::state_t state_reg, state_next;

    logic [cra_pkg::LimW-1:0] slot_limit_reg, slot_limit_next;
    logic [OffW-1:0]          exp_reg, exp_next;
    logic [OffW-1:0]          in_off_reg, in_off_next;
    logic [LenW-1:0]          in_len_reg, in_len_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic                     again_reg, again_next;

    logic                     pend_valid_reg, pend_valid_next;
    logic [SlotW-1:0]         pend_slot_reg, pend_slot_next;
    logic [OffW-1:0]          pend_off_reg, pend_off_next;
    logic [LenW-1:0]          pend_len_reg, pend_len_next;

    logic                     m_valid_reg, m_valid_next;
    cra_pkg::status_t         m_status_reg, m_status_next;
    logic [SlotW-1:0]         m_slot_reg, m_slot_next;
    logic [OffW-1:0]          m_off_reg, m_off_next;
    logic [LenW-1:0]          m_len_reg, m_len_next;
    logic                     m_last_reg, m_last_next;

    cra_pkg::tbl_cmd_t        cmd;
    logic [OffW-1:0]          rd_off;
    logic [LenW-1:0]          rd_len;
    logic [SLOTS-1:0]         used;

    logic [cra_pkg::LimW:0]   lim;
    logic                     used_cur;
    logic                     idx_last;
    logic                     out_free;
    logic                     st_over;
    logic                     st_found;
    logic                     st_done;
    logic                     hit;
    logic                     emit_ok;
    logic                     drain_stall;
    logic                     cnt_max;
    logic                     again_now;
    logic                     to_finish;

    cra_slot_table #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx_reg),
        .wr_offset (in_off_reg),
        .wr_length (in_len_reg),
        .rd_idx    (idx_next),
        .rd_offset (rd_off),
        .rd_length (rd_len),
        .used      (used)
    );

    // effective limit: anything above SLOTS acts as SLOTS
    assign lim = ({1'b0, slot_limit_reg} > (cra_pkg::LimW+1)'(SLOTS)) ?
                 (cra_pkg::LimW+1)'(SLOTS) : {1'b0, slot_limit_reg};

    assign used_cur    = used[idx_reg];
    assign idx_last    = (idx_reg == IW'(SLOTS - 1));
    assign out_free    = !m_valid_reg || m_tready;

    assign st_over     = ((cra_pkg::LimW+1)'(idx_reg) >= lim);
    assign st_found    = !st_over && !used_cur;
    assign st_done     = st_over || !used_cur || idx_last;

    // read data belongs to idx_reg: it was addressed by idx_next last cycle
    assign hit         = used_cur && (rd_off == exp_reg);
    assign emit_ok     = hit && (!pend_valid_reg || out_free);
    assign drain_stall = hit && !emit_ok;
    assign cnt_max     = emit_ok && (cnt_reg == CntW'(cra_pkg::MaxResults - 1));
    assign again_now   = again_reg || (emit_ok && (rd_len != '0));
    assign to_finish   = cnt_max || (idx_last && !drain_stall && !again_now);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cra_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == cra_pkg::ActDrain) ?
                                 cra_pkg::S_DRAIN : cra_pkg::S_STORE;
                end
            end
            cra_pkg::S_STORE:
            begin
                if (st_done && out_free)
                begin
                    state_next = cra_pkg::S_IDLE;
                end
            end
            cra_pkg::S_DRAIN:
            begin
                if (to_finish)
                begin
                    state_next = cra_pkg::S_FINISH;
                end
            end
            cra_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_limit_next = slot_limit_reg;
        exp_next        = exp_reg;
        in_off_next     = in_off_reg;
        in_len_next     = in_len_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        again_next      = again_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_off_next   = pend_off_reg;
        pend_len_next   = pend_len_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_off_next      = m_off_reg;
        m_len_next      = m_len_reg;
        m_last_next     = m_last_reg;
        cmd             = '0;

        unique case (state_reg)
            cra_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_off_next     = s_tdata[OffW-1:0];
                    in_len_next     = s_tdata[OffW+LenW-1:OffW];
                    idx_next        = '0;
                    cnt_next        = '0;
                    again_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            cra_pkg::S_STORE:
            begin
                if (!st_done)
                begin
                    idx_next = idx_reg + IW'(1);
                end
                else if (out_free)
                begin
                    cmd.wr        = st_found;
                    m_valid_next  = 1'b1;
                    m_status_next = st_found ? cra_pkg::ST_STORED : cra_pkg::ST_FULL;
                    m_slot_next   = st_found ? SlotW'(idx_reg) : '0;
                    m_off_next    = '0;
                    m_len_next    = '0;
                    m_last_next   = 1'b1;
                end
            end
            cra_pkg::S_DRAIN:
            begin
                // hold each hit back one step so the final one can carry tlast
                if (emit_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = cra_pkg::ST_EMIT;
                        m_slot_next   = pend_slot_reg;
                        m_off_next    = pend_off_reg;
                        m_len_next    = pend_len_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = SlotW'(idx_reg);
                    pend_off_next   = rd_off;
                    pend_len_next   = rd_len;
                    cmd.clr         = 1'b1;
                    exp_next        = exp_reg + OffW'(rd_len);
                    cnt_next        = cnt_reg + CntW'(1);
                    again_next      = again_now;
                end
                if (!drain_stall && !cnt_max)
                begin
                    if (!idx_last)
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                    else if (again_now)
                    begin
                        idx_next   = '0;
                        again_next = 1'b0;
                    end
                end
            end
            cra_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    m_status_next   = pend_valid_reg ? cra_pkg::ST_EMIT : cra_pkg::ST_NONE;
                    m_slot_next     = pend_valid_reg ? pend_slot_reg : '0;
                    m_off_next      = pend_valid_reg ? pend_off_reg : '0;
                    m_len_next      = pend_valid_reg ? pend_len_reg : '0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                cra_pkg::CfgSlotLimit:
                begin
                    slot_limit_next = cfg_wdata[cra_pkg::LimW-1:0];
                end
                cra_pkg::CfgStartOffset:
                begin
                    exp_next = cfg_wdata;
                end
                default:
                begin
                    exp_next = exp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cra_pkg::S_IDLE;
            slot_limit_reg <= cra_pkg::LimW'(32);
            exp_reg        <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            again_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_limit_reg <= slot_limit_next;
            exp_reg        <= exp_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            again_reg      <= again_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_off_reg    <= in_off_next;
        in_len_reg    <= in_len_next;
        pend_slot_reg <= pend_slot_next;
        pend_off_reg  <= pend_off_next;
        pend_len_reg  <= pend_len_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
        m_off_reg     <= m_off_next;
        m_len_reg     <= m_len_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready = (state_reg == cra_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(cra_pkg::OutDataW - SlotW - OffW - LenW){1'b0}},
                       m_len_reg, m_off_reg, m_slot_reg};

endmodule
